/* hw/rtl/cube_orientation_move_translator_top_macros.svh */
// assertion macros shared by the cube orientation move translator rtl
// expects signals named clock and reset in the including module
`ifndef CUBE_ORIENTATION_MOVE_TRANSLATOR_TOP_MACROS_SVH
`define CUBE_ORIENTATION_MOVE_TRANSLATOR_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define COTR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define COTR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cotr_pkg.sv */
// types, move codes, cube permutations and the control store of the move translator
// no dependencies; used by cotr_useq and the top level
`timescale 1ns / 1ps

package cotr_pkg;

   typedef logic [2:0] face_type;
   typedef logic [2:0] pos_type;
   typedef logic [1:0] turn_type;
   typedef logic [5:0][2:0] orient_type;

   // physical positions
   localparam pos_type POS_U = 3'd0;
   localparam pos_type POS_R = 3'd1;
   localparam pos_type POS_F = 3'd2;
   localparam pos_type POS_D = 3'd3;
   localparam pos_type POS_L = 3'd4;
   localparam pos_type POS_B = 3'd5;

   // logical faces
   localparam face_type FACE_U = 3'd0;
   localparam face_type FACE_R = 3'd1;
   localparam face_type FACE_F = 3'd2;
   localparam face_type FACE_D = 3'd3;
   localparam face_type FACE_L = 3'd4;
   localparam face_type FACE_B = 3'd5;

   localparam turn_type TURN_PLUS  = 2'd0;
   localparam turn_type TURN_MINUS = 2'd1;
   localparam turn_type TURN_HALF  = 2'd2;

   localparam orient_type ORIENT_HOME = {FACE_B, FACE_L, FACE_D, FACE_F, FACE_R, FACE_U};

   typedef enum logic [3:0] {
      MV_ZP   = 4'd0,
      MV_ZM   = 4'd1,
      MV_Z2   = 4'd2,
      MV_YP   = 4'd3,
      MV_YM   = 4'd4,
      MV_Y2   = 4'd5,
      MV_DP   = 4'd6,
      MV_DM   = 4'd7,
      MV_D2   = 4'd8,
      MV_NONE = 4'd9
   } move_type;

   // where the emitted code of a microstep comes from
   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_TURN,
      SRC_FIX
   } src_type;

   // how the last flag of a microstep is decided
   typedef enum logic [1:0] {
      LAST_NEVER,
      LAST_ALWAYS,
      LAST_IF_DONE
   } last_type;

   typedef logic [3:0] uaddr_type;

   // control store addresses
   localparam uaddr_type UA_NONE   = 4'd0;
   localparam uaddr_type UA_TURN   = 4'd1;
   localparam uaddr_type UA_EX_U   = 4'd2;
   localparam uaddr_type UA_EX_R   = 4'd3;
   localparam uaddr_type UA_EX_F   = 4'd4;
   localparam uaddr_type UA_EX_L   = 4'd5;
   localparam uaddr_type UA_EX_B   = 4'd6;
   localparam uaddr_type UA_FIX    = 4'd7;
   localparam uaddr_type UA_RS_Y   = 4'd8;
   localparam uaddr_type UA_RS_U   = 4'd9;
   localparam uaddr_type UA_RS_D   = 4'd10;
   localparam uaddr_type UA_RS_L   = 4'd11;
   localparam uaddr_type UA_RS_B   = 4'd12;
   localparam uaddr_type UA_RS_BY1 = 4'd13;
   localparam uaddr_type UA_RS_BY2 = 4'd14;

   typedef struct packed {
      src_type   src;
      move_type  code;
      last_type  lastm;
      logic      stop;
      uaddr_type nxt;
   } uword_type;

   typedef struct packed {
      logic    found;
      pos_type pos;
   } loc_type;

   function automatic uword_type mk_word(src_type src, move_type code, last_type lastm,
                                         logic stop, uaddr_type nxt);
      uword_type w;
      w.src   = src;
      w.code  = code;
      w.lastm = lastm;
      w.stop  = stop;
      w.nxt   = nxt;
      return w;
   endfunction

   // microprogram: execute chains pre-moves into the d turn, restore brings the front face
   // home with z and y+ moves plus an optional z fix, which comes first when front is at b
   function automatic uword_type rom_word(uaddr_type a);
      uword_type w;
      case (a)
         UA_NONE:   w = mk_word(SRC_CONST, MV_NONE, LAST_ALWAYS,  1'b1, UA_NONE);
         UA_TURN:   w = mk_word(SRC_TURN,  MV_NONE, LAST_ALWAYS,  1'b1, UA_NONE);
         UA_EX_U:   w = mk_word(SRC_CONST, MV_Z2,   LAST_NEVER,   1'b0, UA_TURN);
         UA_EX_R:   w = mk_word(SRC_CONST, MV_ZP,   LAST_NEVER,   1'b0, UA_TURN);
         UA_EX_F:   w = mk_word(SRC_CONST, MV_YP,   LAST_NEVER,   1'b0, UA_EX_L);
         UA_EX_L:   w = mk_word(SRC_CONST, MV_ZM,   LAST_NEVER,   1'b0, UA_TURN);
         UA_EX_B:   w = mk_word(SRC_CONST, MV_YP,   LAST_NEVER,   1'b0, UA_EX_R);
         UA_FIX:    w = mk_word(SRC_FIX,   MV_NONE, LAST_ALWAYS,  1'b1, UA_NONE);
         UA_RS_Y:   w = mk_word(SRC_CONST, MV_YP,   LAST_IF_DONE, 1'b0, UA_FIX);
         UA_RS_U:   w = mk_word(SRC_CONST, MV_ZP,   LAST_NEVER,   1'b0, UA_RS_Y);
         UA_RS_D:   w = mk_word(SRC_CONST, MV_ZM,   LAST_NEVER,   1'b0, UA_RS_Y);
         UA_RS_L:   w = mk_word(SRC_CONST, MV_Z2,   LAST_NEVER,   1'b0, UA_RS_Y);
         UA_RS_B:   w = mk_word(SRC_FIX,   MV_NONE, LAST_NEVER,   1'b0, UA_RS_BY1);
         UA_RS_BY1: w = mk_word(SRC_CONST, MV_YP,   LAST_NEVER,   1'b0, UA_RS_BY2);
         UA_RS_BY2: w = mk_word(SRC_CONST, MV_YP,   LAST_ALWAYS,  1'b1, UA_NONE);
         default:   w = mk_word(SRC_CONST, MV_NONE, LAST_ALWAYS,  1'b1, UA_NONE);
      endcase
      return w;
   endfunction

   // new[p] = old[src[p]] for the six whole-cube moves, d moves leave it alone
   function automatic orient_type rotate(orient_type o, move_type code);
      orient_type r;
      r = o;
      case (code)
         MV_ZP: begin
            r[POS_U] = o[POS_L];
            r[POS_R] = o[POS_U];
            r[POS_D] = o[POS_R];
            r[POS_L] = o[POS_D];
         end
         MV_ZM: begin
            r[POS_U] = o[POS_R];
            r[POS_R] = o[POS_D];
            r[POS_D] = o[POS_L];
            r[POS_L] = o[POS_U];
         end
         MV_Z2: begin
            r[POS_U] = o[POS_D];
            r[POS_R] = o[POS_L];
            r[POS_D] = o[POS_U];
            r[POS_L] = o[POS_R];
         end
         MV_YP: begin
            r[POS_R] = o[POS_B];
            r[POS_F] = o[POS_R];
            r[POS_L] = o[POS_F];
            r[POS_B] = o[POS_L];
         end
         MV_YM: begin
            r[POS_R] = o[POS_F];
            r[POS_F] = o[POS_L];
            r[POS_L] = o[POS_B];
            r[POS_B] = o[POS_R];
         end
         MV_Y2: begin
            r[POS_R] = o[POS_L];
            r[POS_F] = o[POS_B];
            r[POS_L] = o[POS_R];
            r[POS_B] = o[POS_F];
         end
         default: r = o;
      endcase
      return r;
   endfunction

   // z move that brings the up face home, valid with the front face on the f-b axis
   function automatic move_type fix_code(orient_type o);
      move_type m;
      if (o[POS_L] == FACE_U) begin
         m = MV_ZP;
      end else if (o[POS_R] == FACE_U) begin
         m = MV_ZM;
      end else if (o[POS_D] == FACE_U) begin
         m = MV_Z2;
      end else begin
         m = MV_NONE;
      end
      return m;
   endfunction

   function automatic loc_type locate(orient_type o, face_type f);
      loc_type l;
      l.found = 1'b0;
      l.pos   = POS_U;
      for (int p = 5; p >= 0; p--) begin
         if (o[3'(p)] == f) begin
            l.found = 1'b1;
            l.pos   = 3'(p);
         end
      end
      return l;
   endfunction

endpackage

/* hw/rtl/cotr_useq.sv */
// microsequencer of the move translator: program counter that follows the control store
// depends on cotr_pkg (control word type, addresses, rom_word)
`timescale 1ns / 1ps

module cotr_useq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cotr_pkg::uaddr_type  entry,
   input  logic                 step,
   output logic                 busy,
   output cotr_pkg::uword_type  uword
);

   cotr_pkg::uaddr_type pc_ff;
   cotr_pkg::uaddr_type pc_in;
   logic                busy_ff;
   logic                busy_in;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = entry;
         busy_in = 1'b1;
      end else if (step) begin
         if (uword.stop) begin
            busy_in = 1'b0;
         end else begin
            pc_in = uword.nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= cotr_pkg::UA_NONE;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy  = busy_ff;
   assign uword = cotr_pkg::rom_word(pc_ff);

endmodule

/* hw/rtl/cube_orientation_move_translator_top.sv */
// Cube orientation move translator. A command beat either names a logical face and a turn
// (execute) or asks to bring the cube back to its home orientation (restore). The block keeps
// the logical face held at each of the six physical positions and answers each command with
// one to three robot move beats on rsp, the final one with tlast high. Execute gives the
// pre-moves for the face's current position followed by d+, d- or d2; restore gives the
// shortest z+/z-/z2/y+ sequence home, preferring earlier moves in that order. An aligned
// restore, a face code above 5 or a turn code of 3 gives a single none beat. Work is run by
// a small microprogram, one control word per clock while rsp is ready: a command is taken
// in, then runs one to three microsteps (a restore may spend one step on a z fix that turns
// out not needed), and no new command is taken until its last microstep is done.
// A result register holds each beat; while it waits on rsp_tready the microprogram waits too.
// depends on cotr_pkg, cotr_useq and the assertion macro header
`timescale 1ns / 1ps
`include "cube_orientation_move_translator_top_macros.svh"

module cube_orientation_move_translator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // face [2:0], turn [4:3], zero [7:5]
   input  logic       req_tuser,   // command: 0 execute, 1 restore
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // move_code [3:0], zero [7:4]
   output logic       rsp_tlast
);

   cotr_pkg::face_type   req_face;
   cotr_pkg::turn_type   req_turn;
   logic                 req_fire;
   cotr_pkg::uaddr_type  entry;
   cotr_pkg::loc_type    face_loc;
   cotr_pkg::loc_type    front_loc;

   logic                 seq_busy;
   cotr_pkg::uword_type  uword;
   logic                 step;

   cotr_pkg::orient_type orient_ff;
   cotr_pkg::orient_type orient_in;
   cotr_pkg::orient_type rotated;
   cotr_pkg::turn_type   turn_ff;
   cotr_pkg::turn_type   turn_in;

   cotr_pkg::move_type   cur_code;
   logic                 cur_last;
   logic                 emit;
   logic                 out_free;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   cotr_pkg::move_type   rsp_code_ff;
   cotr_pkg::move_type   rsp_code_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;

   logic                 fix_active;
   logic                 front_on_axis;
   logic                 d_beat;

   assign req_face   = req_tdata[2:0];
   assign req_turn   = req_tdata[4:3];
   assign req_tready = !seq_busy;
   assign req_fire   = req_tvalid && req_tready;

   // dispatch: entry point of the microprogram from command and current orientation
   always_comb begin
      face_loc  = cotr_pkg::locate(orient_ff, req_face);
      front_loc = cotr_pkg::locate(orient_ff, cotr_pkg::FACE_F);
      entry     = cotr_pkg::UA_NONE;
      if (req_tuser) begin
         if (orient_ff == cotr_pkg::ORIENT_HOME || !front_loc.found) begin
            entry = cotr_pkg::UA_NONE;
         end else begin
            case (front_loc.pos)
               cotr_pkg::POS_U: entry = cotr_pkg::UA_RS_U;
               cotr_pkg::POS_R: entry = cotr_pkg::UA_RS_Y;
               cotr_pkg::POS_F: entry = cotr_pkg::UA_FIX;
               cotr_pkg::POS_D: entry = cotr_pkg::UA_RS_D;
               cotr_pkg::POS_L: entry = cotr_pkg::UA_RS_L;
               cotr_pkg::POS_B: entry = cotr_pkg::UA_RS_B;
               default:         entry = cotr_pkg::UA_NONE;
            endcase
         end
      end else if (req_face > cotr_pkg::FACE_B || req_turn > cotr_pkg::TURN_HALF ||
                   !face_loc.found) begin
         entry = cotr_pkg::UA_NONE;
      end else begin
         case (face_loc.pos)
            cotr_pkg::POS_U: entry = cotr_pkg::UA_EX_U;
            cotr_pkg::POS_R: entry = cotr_pkg::UA_EX_R;
            cotr_pkg::POS_F: entry = cotr_pkg::UA_EX_F;
            cotr_pkg::POS_D: entry = cotr_pkg::UA_TURN;
            cotr_pkg::POS_L: entry = cotr_pkg::UA_EX_L;
            cotr_pkg::POS_B: entry = cotr_pkg::UA_EX_B;
            default:         entry = cotr_pkg::UA_NONE;
         endcase
      end
   end

   cotr_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .entry (entry),
      .step  (step),
      .busy  (seq_busy),
      .uword (uword)
   );

   // datapath driven by the current control word
   always_comb begin
      case (uword.src)
         cotr_pkg::SRC_CONST: cur_code = uword.code;
         cotr_pkg::SRC_TURN:
            cur_code = cotr_pkg::move_type'(4'(int'(cotr_pkg::MV_DP) + int'(turn_ff)));
         cotr_pkg::SRC_FIX:   cur_code = cotr_pkg::fix_code(orient_ff);
         default:             cur_code = cotr_pkg::MV_NONE;
      endcase

      // a fix step with nothing to fix produces no beat
      emit    = !(uword.src == cotr_pkg::SRC_FIX && cur_code == cotr_pkg::MV_NONE);
      rotated = cotr_pkg::rotate(orient_ff, cur_code);

      case (uword.lastm)
         cotr_pkg::LAST_NEVER:   cur_last = 1'b0;
         cotr_pkg::LAST_ALWAYS:  cur_last = 1'b1;
         cotr_pkg::LAST_IF_DONE: cur_last = (cotr_pkg::fix_code(rotated) == cotr_pkg::MV_NONE);
         default:                cur_last = 1'b1;
      endcase

      out_free = !rsp_valid_ff || rsp_tready;
      step     = seq_busy && (!emit || out_free);
   end

   always_comb begin
      orient_in    = orient_ff;
      turn_in      = turn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_fire) begin
         turn_in = req_turn;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         orient_in = rotated;
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = cur_code;
            rsp_last_in  = cur_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff    <= cotr_pkg::ORIENT_HOME;
         rsp_valid_ff <= 1'b0;
      end else begin
         orient_ff    <= orient_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      turn_ff     <= turn_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, 4'(rsp_code_ff)};
   assign rsp_tlast  = rsp_last_ff;

   assign fix_active    = seq_busy && uword.src == cotr_pkg::SRC_FIX;
   assign front_on_axis = orient_ff[cotr_pkg::POS_F] == cotr_pkg::FACE_F ||
                          orient_ff[cotr_pkg::POS_B] == cotr_pkg::FACE_F;
   assign d_beat        = step && emit && (cur_code == cotr_pkg::MV_DP ||
                          cur_code == cotr_pkg::MV_DM || cur_code == cotr_pkg::MV_D2);

   `COTR_ASSERT_NXT(a_idle_holds_orient, !seq_busy, $stable(orient_ff), "orient moved while idle")
   `COTR_ASSERT_IMP(a_fix_on_fb_axis, fix_active, front_on_axis, "z fix with front off the f-b axis")
   `COTR_ASSERT_IMP(a_d_move_is_last, d_beat, cur_last, "d move not marked last")

endmodule
